/* rtl/core/multichannel_ring_history_unit_defines.svh */
// Assertion macros used by the checker of the history unit.
`ifndef MULTICHANNEL_RING_HISTORY_UNIT_DEFINES_SVH
`define MULTICHANNEL_RING_HISTORY_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define MRH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define MRH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mrh_pkg.sv */
`default_nettype none
package mrh_pkg;

  localparam int SLOTS_DEF  = 8;
  localparam int DEPTH_DEF  = 64;
  localparam int WINDOW_MAX = 64;

  localparam int SAMPLE_W = 16;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = 7;
  localparam int TIME_W   = 32;

  localparam logic [SAMPLE_W-1:0] NO_READING_RST = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SETUP,
    ST_START,
    ST_STREAM,
    ST_FLAG
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic [CNT_W-1:0]           window_count;
    logic [TIME_W-1:0]          newest_time;
    logic                       slot_error;
    logic                       last;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } out_push_t;

endpackage
`default_nettype wire

/* rtl/core/mrh_if.sv */
`default_nettype none
interface mrh_req_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [mrh_pkg::SAMPLE_W-1:0] reading;
  logic                                reading_present;
  logic                                row_end;
  logic [mrh_pkg::TIME_W-1:0]          now_time;
  logic [mrh_pkg::SLOT_W-1:0]          slot;
  logic [mrh_pkg::CNT_W-1:0]           max_wanted;

  modport source (
    output valid, func, reading, reading_present, row_end, now_time, slot, max_wanted,
    input  ready
  );
  modport sink (
    input  valid, func, reading, reading_present, row_end, now_time, slot, max_wanted,
    output ready
  );
endinterface

interface mrh_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mrh_pkg::SAMPLE_W-1:0] sample;
  logic                                sample_valid;
  logic [mrh_pkg::CNT_W-1:0]           window_count;
  logic [mrh_pkg::TIME_W-1:0]          newest_time;
  logic                                slot_error;
  logic                                last;

  modport source (
    output valid, sample, sample_valid, window_count, newest_time, slot_error, last,
    input  ready
  );
  modport sink (
    input  valid, sample, sample_valid, window_count, newest_time, slot_error, last,
    output ready
  );
endinterface

interface mrh_cfg_if;
  logic                                valid;
  logic                                ready;
  logic signed [mrh_pkg::SAMPLE_W-1:0] no_reading_value;

  modport source (output valid, no_reading_value, input ready);
  modport sink (input valid, no_reading_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/mrh_store.sv */
`default_nettype none
module mrh_store #(
  parameter int ADDR_W = 9
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [ADDR_W-1:0]            wr_addr,
  input  wire logic [mrh_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [ADDR_W-1:0]            rd_addr,
  output logic      [mrh_pkg::SAMPLE_W-1:0] rd_data
);

  logic [mrh_pkg::SAMPLE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mrh_outreg.sv */
`default_nettype none
module mrh_outreg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mrh_pkg::out_push_t push,
  output logic                    free,
  mrh_rsp_if.source               rsp
);

  logic             valid;
  mrh_pkg::result_t data;

  assign free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push.load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.load) begin
      data <= push.res;
    end
  end

  assign rsp.valid        = valid;
  assign rsp.sample       = data.sample;
  assign rsp.sample_valid = data.sample_valid;
  assign rsp.window_count = data.window_count;
  assign rsp.newest_time  = data.newest_time;
  assign rsp.slot_error   = data.slot_error;
  assign rsp.last         = data.last;

endmodule
`default_nettype wire

/* rtl/core/mrh_ctrl.sv */
`default_nettype none
module mrh_ctrl #(
  parameter int  SLOTS = mrh_pkg::SLOTS_DEF,
  parameter int  DEPTH = mrh_pkg::DEPTH_DEF,
  localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int RW    = $clog2(DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  mrh_req_if.sink                               req,
  mrh_cfg_if.sink                               cfg,
  output logic                                  wr_en,
  output logic [SIW+RW-1:0]                     wr_addr,
  output logic [mrh_pkg::SAMPLE_W-1:0]          wr_data,
  output logic                                  rd_en,
  output logic [SIW+RW-1:0]                     rd_addr,
  input  wire logic [mrh_pkg::SAMPLE_W-1:0]     rd_data,
  output mrh_pkg::out_push_t                    push,
  input  wire logic                             out_free
);

  localparam int FSW = $clog2(SLOTS + 1);
  localparam int AW  = RW + 1;
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int CW  = mrh_pkg::CNT_W;
  localparam int MW  = (FW > CW) ? FW : CW;
  localparam int SCW = mrh_pkg::SLOT_W + 1;

  mrh_pkg::state_t state, state_next;

  logic [mrh_pkg::SAMPLE_W-1:0] no_reading, no_reading_next;
  logic [RW-1:0]                head, head_next;
  logic [FW-1:0]                filled, filled_next;
  logic [mrh_pkg::TIME_W-1:0]   stamp, stamp_next;
  logic [FSW-1:0]               fill, fill_next;
  logic [SIW-1:0]               rd_slot, rd_slot_next;
  logic [CW-1:0]                want, want_next;
  logic                         err, err_next;
  logic [CW-1:0]                count, count_next;
  logic [CW-1:0]                rem, rem_next;
  logic [RW-1:0]                row, row_next;

  logic [MW-1:0] filled_ext, want_ext;
  logic [CW-1:0] n_c;
  logic [AW-1:0] start_sum;
  logic [RW-1:0] start_c;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] head_inc;
  logic          fill_open;

  assign filled_ext = MW'(filled);
  assign want_ext   = MW'(want);
  assign n_c        = CW'((filled_ext < want_ext) ? filled_ext : want_ext);
  assign start_sum  = AW'(head) + AW'(DEPTH) - AW'(count);
  assign start_c    = (start_sum >= AW'(DEPTH)) ? RW'(start_sum - AW'(DEPTH)) : RW'(start_sum);
  assign row_inc    = (row == RW'(DEPTH - 1)) ? '0 : row + 1'b1;
  assign head_inc   = (head == RW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign fill_open  = fill < FSW'(SLOTS);

  assign cfg.ready       = 1'b1;
  assign no_reading_next = cfg.valid ? cfg.no_reading_value : no_reading;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mrh_pkg::ST_IDLE;
      no_reading <= mrh_pkg::NO_READING_RST;
      head       <= '0;
      filled     <= '0;
      stamp      <= '0;
      fill       <= '0;
    end else begin
      state      <= state_next;
      no_reading <= no_reading_next;
      head       <= head_next;
      filled     <= filled_next;
      stamp      <= stamp_next;
      fill       <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_slot_next;
    want    <= want_next;
    err     <= err_next;
    count   <= count_next;
    rem     <= rem_next;
    row     <= row_next;
  end

  always_comb begin
    state_next   = state;
    head_next    = head;
    filled_next  = filled;
    stamp_next   = stamp;
    fill_next    = fill;
    rd_slot_next = rd_slot;
    want_next    = want;
    err_next     = err;
    count_next   = count;
    rem_next     = rem;
    row_next     = row;
    req.ready    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = {fill[SIW-1:0], head};
    wr_data      = req.reading;
    rd_en        = 1'b0;
    rd_addr      = {rd_slot, row};
    push         = '0;

    unique case (state)
      mrh_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (!req.func) begin
            if (req.reading_present && fill_open) begin
              wr_en     = 1'b1;
              fill_next = fill + 1'b1;
            end
            if (req.row_end) begin
              stamp_next = req.now_time;
              state_next = mrh_pkg::ST_FILL;
            end
          end else begin
            rd_slot_next = req.slot[SIW-1:0];
            want_next    = (req.max_wanted > CW'(mrh_pkg::WINDOW_MAX)) ?
                           CW'(mrh_pkg::WINDOW_MAX) : req.max_wanted;
            if ({1'b0, req.slot} >= SCW'(SLOTS)) begin
              err_next   = 1'b1;
              state_next = mrh_pkg::ST_FLAG;
            end else begin
              err_next   = 1'b0;
              state_next = mrh_pkg::ST_SETUP;
            end
          end
        end
      end
      mrh_pkg::ST_FILL: begin
        if (fill_open) begin
          wr_en     = 1'b1;
          wr_data   = no_reading;
          fill_next = fill + 1'b1;
        end else begin
          head_next   = head_inc;
          filled_next = (filled == FW'(DEPTH)) ? filled : filled + 1'b1;
          fill_next   = '0;
          state_next  = mrh_pkg::ST_IDLE;
        end
      end
      mrh_pkg::ST_SETUP: begin
        count_next = n_c;
        rem_next   = n_c;
        state_next = (n_c == '0) ? mrh_pkg::ST_FLAG : mrh_pkg::ST_START;
      end
      mrh_pkg::ST_START: begin
        rd_en      = 1'b1;
        rd_addr    = {rd_slot, start_c};
        row_next   = start_c;
        state_next = mrh_pkg::ST_STREAM;
      end
      mrh_pkg::ST_STREAM: begin
        if (out_free) begin
          push.load             = 1'b1;
          push.res.sample       = rd_data;
          push.res.sample_valid = 1'b1;
          push.res.window_count = count;
          push.res.newest_time  = stamp;
          push.res.slot_error   = 1'b0;
          push.res.last         = (rem == CW'(1));
          rem_next              = rem - 1'b1;
          if (rem == CW'(1)) begin
            state_next = mrh_pkg::ST_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = {rd_slot, row_inc};
            row_next = row_inc;
          end
        end
      end
      mrh_pkg::ST_FLAG: begin
        if (out_free) begin
          push.load            = 1'b1;
          push.res.newest_time = err ? '0 : stamp;
          push.res.slot_error  = err;
          push.res.last        = 1'b1;
          state_next           = mrh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mrh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/multichannel_ring_history_unit.sv */
// Write item without row end: 1 cycle. Row end: 2 + (SLOTS - readings in row) cycles,
// one unfilled slot written per cycle through the single store write port.
// Read: first sample registered 3 cycles after accept, then one per cycle while the
// output is taken; busy for 3 + window_count cycles. Bad slot or empty window: 2 or 3.
// Reset clears head, fill count, timestamp and row position, and sets no_reading_value
// to -32768; store contents stay undefined, no clearing pass.
`default_nettype none
module multichannel_ring_history_unit #(
  parameter int SLOTS = mrh_pkg::SLOTS_DEF,
  parameter int DEPTH = mrh_pkg::DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  mrh_req_if.sink  req,
  mrh_rsp_if.source rsp,
  mrh_cfg_if.sink  cfg
);

  localparam int SIW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW     = $clog2(DEPTH);
  localparam int ADDR_W = SIW + RW;

  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [mrh_pkg::SAMPLE_W-1:0] wr_data;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [mrh_pkg::SAMPLE_W-1:0] rd_data;
  mrh_pkg::out_push_t           push;
  logic                         out_free;

  mrh_ctrl #(
    .SLOTS(SLOTS),
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .push    (push),
    .out_free(out_free)
  );

  mrh_store #(
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mrh_outreg u_outreg (
    .clk (clk),
    .rst (rst),
    .push(push),
    .free(out_free),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

/* rtl/core/mrh_checker.sv */
`default_nettype none
`include "multichannel_ring_history_unit_defines.svh"
module mrh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        req_func,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] rsp_sample,
  input wire logic        rsp_sample_valid,
  input wire logic [6:0]  rsp_window_count,
  input wire logic [31:0] rsp_newest_time,
  input wire logic        rsp_slot_error,
  input wire logic        rsp_last
);

  `MRH_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_sample) && $stable(rsp_last) && $stable(rsp_window_count),
    "result changed while stalled")

  `MRH_ASSERT_NOW(a_flag_last, clk, rst, rsp_valid && !rsp_sample_valid,
    rsp_last && rsp_window_count == 7'd0, "flagged item not a lone last item")

  `MRH_ASSERT_NOW(a_err_fields, clk, rst, rsp_valid && rsp_slot_error,
    !rsp_sample_valid && rsp_newest_time == 32'd0, "bad slot item carries data")

  `MRH_ASSERT_NOW(a_count_range, clk, rst, rsp_valid && rsp_sample_valid,
    rsp_window_count != 7'd0 && rsp_window_count <= 7'd64 && !rsp_slot_error,
    "sample item with bad window count")

  `MRH_ASSERT_NEXT(a_read_busy, clk, rst, req_valid && req_ready && req_func,
    !req_ready, "read accepted back to back")

endmodule

bind multichannel_ring_history_unit mrh_checker u_mrh_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_func        (req.func),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_sample      (rsp.sample),
  .rsp_sample_valid(rsp.sample_valid),
  .rsp_window_count(rsp.window_count),
  .rsp_newest_time (rsp.newest_time),
  .rsp_slot_error  (rsp.slot_error),
  .rsp_last        (rsp.last)
);
`default_nettype wire
